[rtl/mmfn_pkg.sv]
// ----------------------------------------------------------------------------
// mmfn_pkg
// Shared constants, action codes and sequencer states of the min-max
// feature normalizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mmfn_pkg;

    localparam int FEATURES_DEF   = 64;
    localparam int VALUE_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int ACTION_W       = 2;
    localparam int INDEX_W        = 6;

    typedef enum logic [ACTION_W-1:0] {
        ACT_OBSERVE   = 2'd0,
        ACT_NORMALIZE = 2'd1,
        ACT_CLEAR     = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SETUP,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

[rtl/mmfn_if.sv]
// ----------------------------------------------------------------------------
// mmfn_if
// Valid/ready channels of the normalizer: request words in, result words out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mmfn_in_if #(
    parameter int VALUE_BITS = mmfn_pkg::VALUE_BITS_DEF
);
    import mmfn_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [ACTION_W-1:0]          action;
    logic [INDEX_W-1:0]           feature_index;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output action, output feature_index, output value,
                    input ready);
    modport sink   (input valid, input action, input feature_index, input value,
                    output ready);
endinterface

interface mmfn_out_if #(
    parameter int VALUE_BITS = mmfn_pkg::VALUE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] scaled;
    logic                         saturated;

    modport source (output valid, output scaled, output saturated, input ready);
    modport sink   (input valid, input scaled, input saturated, output ready);
endinterface

[rtl/mmfn_ram.sv]
// ----------------------------------------------------------------------------
// mmfn_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mmfn_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/mmfn_div.sv]
// ----------------------------------------------------------------------------
// mmfn_div
// Restoring divider, one quotient bit per cycle. Divides mag * 2^FRAC_BITS
// by den; quotient bits shifted past the top set a sticky overflow flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mmfn_div #(
    parameter int VALUE_BITS = mmfn_pkg::VALUE_BITS_DEF,
    parameter int FRAC_BITS  = mmfn_pkg::FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [VALUE_BITS:0]   i_mag,
    input  logic [VALUE_BITS-1:0] i_den,
    output logic                  o_done,
    output logic [VALUE_BITS:0]   o_quot,
    output logic                  o_ovf
);
    localparam int NB = VALUE_BITS + 1 + FRAC_BITS;
    localparam int CW = $clog2(NB + 1);

    logic [NB-1:0]         r_num;
    logic [VALUE_BITS-1:0] r_rem;
    logic [VALUE_BITS-1:0] r_den;
    logic [VALUE_BITS:0]   r_q;
    logic                  r_ovf;
    logic [CW-1:0]         r_cnt;
    logic                  r_done;

    logic [VALUE_BITS:0]   trial;
    logic [VALUE_BITS:0]   sub;
    logic                  ge;

    assign trial = {r_rem, r_num[NB-1]};
    assign sub   = trial - {1'b0, r_den};
    assign ge    = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(NB);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= {i_mag, {FRAC_BITS{1'b0}}};
            r_rem <= '0;
            r_den <= i_den;
            r_q   <= '0;
            r_ovf <= 1'b0;
        end else if (r_cnt != '0) begin
            r_num <= {r_num[NB-2:0], 1'b0};
            // rem stays below den, so either branch fits in VALUE_BITS
            r_rem <= ge ? sub[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
            r_q   <= {r_q[VALUE_BITS-1:0], ge};
            r_ovf <= r_ovf | r_q[VALUE_BITS];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_ovf  = r_ovf;

endmodule

[rtl/min_max_feature_normalizer.sv]
// ----------------------------------------------------------------------------
// min_max_feature_normalizer
// Per-feature min-max scaler. Each request word carries an action, a feature
// index and a signed fixed-point value. Observe widens that feature's learned
// [low, high] range (held in a RAM) and marks it seen; clear forgets every
// range; normalize returns one result word, (value - low) / (high - low) in
// the same fixed-point format, truncated toward zero and saturated, with a
// divisor of 1.0 when the range is empty. A feature never seen answers the
// most negative value with the saturated flag set. States from one accepted
// request to the next: clear, action code 3 and observe go EXEC, IDLE;
// normalize of a seen feature goes EXEC, SETUP, DIV, DONE, with values Q16.16
// at the default and DIV paced by the bit-serial divider that produces one
// quotient bit per cycle; normalize of a never seen feature goes EXEC, DONE.
// The block takes one request at a time. A result waits in an output register,
// so the next request is taken while it is pending; a normalize result that
// finds that register still full stalls until the receiver takes the word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module min_max_feature_normalizer #(
    parameter int FEATURES   = mmfn_pkg::FEATURES_DEF,
    parameter int VALUE_BITS = mmfn_pkg::VALUE_BITS_DEF,
    parameter int FRAC_BITS  = mmfn_pkg::FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mmfn_in_if.sink   i_in,
    mmfn_out_if.source o_out
);
    import mmfn_pkg::*;

    localparam int AW = (FEATURES > 1) ? $clog2(FEATURES) : 1;
    localparam int VB = VALUE_BITS;
    localparam logic [VB-1:0] SIGN_MIN = {1'b1, {(VB-1){1'b0}}};
    localparam logic [VB-1:0] POS_MAX  = {1'b0, {(VB-1){1'b1}}};
    localparam logic [VB-1:0] ONE      = {{(VB-1){1'b0}}, 1'b1} << FRAC_BITS;

    t_state                 r_state, n_state;
    logic [ACTION_W-1:0]    r_act;
    logic [AW-1:0]          r_addr;
    logic                   r_inrange;
    logic signed [VB-1:0]   r_value;
    logic [FEATURES-1:0]    r_seen;
    logic                   r_hit;
    logic signed [VB:0]     r_diff;
    logic signed [VB:0]     r_span;
    logic                   r_neg;
    logic                   r_out_valid;
    logic [VB-1:0]          r_scaled;
    logic                   r_sat;

    logic                   accept;
    logic [INDEX_W+AW-1:0]  idx_ext;
    logic [AW-1:0]          in_addr;
    logic                   in_range;
    logic                   hit;

    logic                   ram_we;
    logic [2*VB-1:0]        ram_wdata;
    logic [2*VB-1:0]        ram_rdata;
    logic signed [VB-1:0]   cur_low, cur_high, new_low, new_high;

    logic                   seen_set, seen_clr, load_math, load_out;
    logic                   div_start, div_done, div_ovf;
    logic [VB:0]            div_quot;
    logic [VB:0]            mag;
    logic [VB-1:0]          den;
    logic [VB:0]            limit;
    logic                   over;
    logic [VB-1:0]          res_scaled;

    assign accept   = i_in.valid && i_in.ready;
    assign idx_ext  = (INDEX_W + AW)'(i_in.feature_index);
    assign in_addr  = idx_ext[AW-1:0];
    assign in_range = (int'(i_in.feature_index) < FEATURES);
    assign hit      = r_inrange && r_seen[r_addr];

    assign i_in.ready = (r_state == ST_IDLE);

    // range store: {high, low} per feature
    mmfn_ram #(
        .WIDTH (2 * VB),
        .DEPTH (FEATURES)
    ) u_range_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (ram_wdata),
        .i_raddr (in_addr),
        .o_rdata (ram_rdata)
    );

    assign cur_low   = $signed(ram_rdata[VB-1:0]);
    assign cur_high  = $signed(ram_rdata[2*VB-1:VB]);
    assign new_low   = (!hit || (r_value < cur_low))  ? r_value : cur_low;
    assign new_high  = (!hit || (r_value > cur_high)) ? r_value : cur_high;
    assign ram_wdata = {new_high, new_low};

    assign mag = r_diff[VB] ? (VB+1)'(0) - r_diff : r_diff;
    assign den = (r_span <= 0) ? ONE : r_span[VB-1:0];

    mmfn_div #(
        .VALUE_BITS (VB),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_mag   (mag),
        .i_den   (den),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_ovf   (div_ovf)
    );

    assign limit      = r_neg ? {1'b0, SIGN_MIN} : {1'b0, POS_MAX};
    assign over       = !r_hit || div_ovf || (div_quot > limit);
    assign res_scaled = !r_hit ? SIGN_MIN :
                        over   ? (r_neg ? SIGN_MIN : POS_MAX) :
                        r_neg  ? (VB'(0) - div_quot[VB-1:0]) : div_quot[VB-1:0];

    always_comb begin
        n_state   = r_state;
        ram_we    = 1'b0;
        seen_set  = 1'b0;
        seen_clr  = 1'b0;
        load_math = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
                unique case (r_act)
                    ACT_OBSERVE: begin
                        ram_we   = r_inrange;
                        seen_set = r_inrange;
                    end
                    ACT_NORMALIZE: begin
                        load_math = 1'b1;
                        n_state   = hit ? ST_SETUP : ST_DONE;
                    end
                    ACT_CLEAR: begin
                        seen_clr = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            ST_SETUP: begin
                div_start = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_seen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (seen_clr) begin
                r_seen <= '0;
            end else if (seen_set) begin
                r_seen[r_addr] <= 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act     <= i_in.action;
            r_addr    <= in_addr;
            r_inrange <= in_range;
            r_value   <= i_in.value;
        end
        if (load_math) begin
            r_hit  <= hit;
            r_diff <= (VB+1)'(r_value) - (VB+1)'(cur_low);
            r_span <= (VB+1)'(cur_high) - (VB+1)'(cur_low);
        end
        if (div_start) begin
            r_neg <= r_diff[VB];
        end
        if (load_out) begin
            r_scaled <= res_scaled;
            r_sat    <= over;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.scaled    = $signed(r_scaled);
    assign o_out.saturated = r_sat;

endmodule
